/* hdl/shd_pkg.sv */
`timescale 1ns / 1ps

package shd_pkg;

  // header layout
  localparam int WIN_DEPTH     = 15;
  localparam int WIN_IDX_W     = $clog2(WIN_DEPTH);
  localparam int WIN_FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int TYPE_W        = 56;
  localparam int LEN_W         = 24;
  localparam int DROP_W        = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] MARK_A   = 8'h55;
  localparam logic [7:0] MARK_B   = 8'hAA;
  localparam logic [7:0] TAG_T    = 8'h54;
  localparam logic [7:0] TAG_LEN  = 8'h22;

  // result kinds
  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } shd_kind_t;

  // one result item
  typedef struct packed {
    shd_kind_t          kind;
    logic [TYPE_W-1:0]  type_code;
    logic [LEN_W-1:0]   payload_length;
    logic [7:0]         payload_byte;
    logic               last_of_packet;
    logic [DROP_W-1:0]  dropped_count;
  } shd_result_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } shd_qstat_t;

endpackage

/* hdl/shd_front.sv */
`timescale 1ns / 1ps

module shd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  output logic                in_stall,
  input  shd_pkg::shd_qstat_t q_stat,
  output logic                push,
  output shd_pkg::shd_result_t push_data
);

  logic [7:0]                      win_r [shd_pkg::WIN_DEPTH];
  logic [7:0]                      win_nxt [shd_pkg::WIN_DEPTH];
  logic [shd_pkg::WIN_FILL_W-1:0]  fill_r, fill_nxt;
  logic                            in_payload_r, in_payload_nxt;
  logic [shd_pkg::LEN_W-1:0]       remain_r, remain_nxt;
  logic [shd_pkg::DROP_W-1:0]      drop_r, drop_nxt;

  logic                            accept;
  logic                            win_full;
  logic                            hdr_match;
  logic [shd_pkg::LEN_W-1:0]       hdr_len;
  logic [shd_pkg::LEN_W-1:0]       remain_dec;

  // take a byte whenever the queue has room
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // header compare over the full window plus the new byte
  assign win_full  = (fill_r == shd_pkg::WIN_FILL_W'(shd_pkg::WIN_DEPTH));
  assign hdr_match = (win_r[0] == shd_pkg::MARK_A) && (win_r[1] == shd_pkg::MARK_B) &&
                     (win_r[2] == shd_pkg::MARK_A) && (win_r[3] == shd_pkg::MARK_B) &&
                     (win_r[4] == shd_pkg::TAG_T) && (win_r[12] == shd_pkg::TAG_LEN);
  assign hdr_len    = {win_r[13], win_r[14], in_data_byte};
  assign remain_dec = remain_r - shd_pkg::LEN_W'(1);

  // classify the byte and update the hunt state
  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    in_payload_nxt = in_payload_r;
    remain_nxt     = remain_r;
    drop_nxt       = drop_r;
    push           = 1'b0;
    push_data      = '0;
    push_data.dropped_count = drop_r;
    if (accept) begin
      if (in_payload_r) begin
        remain_nxt               = remain_dec;
        in_payload_nxt           = (remain_dec != '0);
        push                     = 1'b1;
        push_data.kind           = shd_pkg::KIND_PAYLOAD;
        push_data.payload_byte   = in_data_byte;
        push_data.last_of_packet = (remain_dec == '0);
      end else if (!win_full) begin
        win_nxt[fill_r[shd_pkg::WIN_IDX_W-1:0]] = in_data_byte;
        fill_nxt = fill_r + shd_pkg::WIN_FILL_W'(1);
      end else if (hdr_match) begin
        // window needs no clear: it is refilled before the next compare
        fill_nxt                 = '0;
        remain_nxt               = hdr_len;
        in_payload_nxt           = (hdr_len != '0);
        push                     = 1'b1;
        push_data.kind           = shd_pkg::KIND_HEADER;
        push_data.type_code      = {win_r[5], win_r[6], win_r[7], win_r[8],
                                    win_r[9], win_r[10], win_r[11]};
        push_data.payload_length = hdr_len;
        push_data.last_of_packet = (hdr_len == '0);
      end else begin
        for (int i = 0; i < shd_pkg::WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[shd_pkg::WIN_DEPTH - 1] = in_data_byte;
        if (drop_r != '1) begin
          drop_nxt = drop_r + shd_pkg::DROP_W'(1);
        end
      end
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      in_payload_r <= 1'b0;
      remain_r     <= '0;
      drop_r       <= '0;
    end else begin
      fill_r       <= fill_nxt;
      in_payload_r <= in_payload_nxt;
      remain_r     <= remain_nxt;
      drop_r       <= drop_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (remain_r != '0))
    else $error("payload mode with no bytes left");
  a_drop_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r == '1) |=> (drop_r == '1))
    else $error("drop count wrapped");
  a_no_hunt_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |=> (fill_r == $past(fill_r)))
    else $error("window changed during payload");
`endif

endmodule

/* hdl/shd_queue.sv */
`timescale 1ns / 1ps

module shd_queue #(
  parameter int DEPTH = shd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  shd_pkg::shd_result_t push_data,
  input  logic                 pop,
  output shd_pkg::shd_result_t pop_data,
  output shd_pkg::shd_qstat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  shd_pkg::shd_result_t entry_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("item pushed into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* hdl/shd_back.sv */
`timescale 1ns / 1ps

module shd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  shd_pkg::shd_qstat_t        q_stat,
  input  shd_pkg::shd_result_t       pop_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [shd_pkg::TYPE_W-1:0] out_type_code,
  output logic [shd_pkg::LEN_W-1:0]  out_payload_length,
  output logic [7:0]                 out_payload_byte,
  output logic                       out_last_of_packet,
  output logic [shd_pkg::DROP_W-1:0] out_dropped_count
);

  logic                 valid_r, valid_nxt;
  shd_pkg::shd_result_t res_r;
  logic                 load;

  // refill the output register when it is empty or being taken
  assign load      = !q_stat.empty && (!valid_r || !out_stall);
  assign pop       = load;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result ports
  assign out_valid          = valid_r;
  assign out_kind           = res_r.kind;
  assign out_type_code      = res_r.type_code;
  assign out_payload_length = res_r.payload_length;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_last_of_packet = res_r.last_of_packet;
  assign out_dropped_count  = res_r.dropped_count;

endmodule

/* hdl/sync_header_deframer.sv */
`timescale 1ns / 1ps

// Byte stream deframer: takes one byte per clock unless stalled, and hunts for a
// 16-byte header (55 AA 55 AA, 'T', seven type bytes, 0x22, 24-bit big-endian
// length) in a 15-byte sliding window, compared in parallel with each new byte.
// A match gives one header item with the type and length, then exactly that many
// payload items follow, the last one flagged. Bytes pushed out of a full window
// while hunting raise a saturating dropped count carried in every item. The
// classifier feeds a short result queue (QUEUE_DEPTH entries) and a registered
// output stage, so the block sustains one byte per clock while out_stall is low.
// The result of a taken byte passes through the queue and output register to
// out_valid; in_stall rises only when the queue fills because output is held off.

module sync_header_deframer #(
  parameter int QUEUE_DEPTH = shd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [shd_pkg::TYPE_W-1:0] out_type_code,
  output logic [shd_pkg::LEN_W-1:0]  out_payload_length,
  output logic [7:0]                 out_payload_byte,
  output logic                       out_last_of_packet,
  output logic [shd_pkg::DROP_W-1:0] out_dropped_count
);

  shd_pkg::shd_qstat_t  q_stat;
  shd_pkg::shd_result_t push_data;
  shd_pkg::shd_result_t pop_data;
  logic                 push;
  logic                 pop;

  // hunt and classify
  shd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // result queue between the two sides
  shd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // output register
  shd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_type_code      (out_type_code),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_of_packet (out_last_of_packet),
    .out_dropped_count  (out_dropped_count)
  );

endmodule

/* test/sync_header_deframer_tb.sv */
`timescale 1ns / 1ps

module sync_header_deframer_tb;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_data_byte = 8'h00;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_kind;
  logic [shd_pkg::TYPE_W-1:0]   out_type_code;
  logic [shd_pkg::LEN_W-1:0]    out_payload_length;
  logic [7:0]                   out_payload_byte;
  logic                         out_last_of_packet;
  logic [shd_pkg::DROP_W-1:0]   out_dropped_count;

  sync_header_deframer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_type_code      (out_type_code),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_of_packet (out_last_of_packet),
    .out_dropped_count  (out_dropped_count)
  );

  // clock
  always #5 clk = ~clk;

  // stream bytes waiting to be sent and results waiting to be seen
  logic [7:0]           stream_q[$];
  shd_pkg::shd_result_t expected_results[$];
  int                   total_bytes = 0;
  int                   bytes_taken = 0;
  int                   mismatches = 0;

  // deframer shadow state
  logic [7:0]                 win [shd_pkg::WIN_DEPTH];
  int                         win_fill = 0;
  logic                       in_pkt = 1'b0;
  logic [shd_pkg::LEN_W-1:0]  left = '0;
  logic [shd_pkg::DROP_W-1:0] drops = '0;

  // idle lengths: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // next calm stretch: no idling for a while now and then
  function automatic int next_calm(input int calm);
    if (calm > 0) return calm - 1;
    if ($urandom_range(0, 49) == 0) return $urandom_range(20, 80);
    return 0;
  endfunction

  // append to the pending streams
  function automatic void queue_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function automatic void queue_result(input shd_pkg::shd_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // work out what one accepted byte causes
  function automatic void deframe_byte(input logic [7:0] b);
    shd_pkg::shd_result_t r;
    logic [shd_pkg::LEN_W-1:0] len;
    r = '0;
    if (in_pkt) begin
      left = left - shd_pkg::LEN_W'(1);
      r.kind = shd_pkg::KIND_PAYLOAD;
      r.payload_byte = b;
      r.last_of_packet = (left == '0);
      r.dropped_count = drops;
      if (left == '0) in_pkt = 1'b0;
      queue_result(r);
    end else if (win_fill < shd_pkg::WIN_DEPTH) begin
      win[win_fill] = b;
      win_fill++;
    end else if (win[0] == shd_pkg::MARK_A && win[1] == shd_pkg::MARK_B &&
                 win[2] == shd_pkg::MARK_A && win[3] == shd_pkg::MARK_B &&
                 win[4] == shd_pkg::TAG_T && win[12] == shd_pkg::TAG_LEN) begin
      len = {win[13], win[14], b};
      r.kind = shd_pkg::KIND_HEADER;
      for (int i = 5; i < 12; i++)
        r.type_code = {r.type_code[shd_pkg::TYPE_W-9:0], win[i]};
      r.payload_length = len;
      r.last_of_packet = (len == '0);
      r.dropped_count = drops;
      queue_result(r);
      for (int i = 0; i < shd_pkg::WIN_DEPTH; i++) win[i] = 8'h00;
      win_fill = 0;
      left = len;
      in_pkt = (len != '0);
    end else begin
      for (int i = 0; i + 1 < shd_pkg::WIN_DEPTH; i++) win[i] = win[i + 1];
      win[shd_pkg::WIN_DEPTH - 1] = b;
      if (drops != '1) drops = drops + shd_pkg::DROP_W'(1);
    end
  endfunction

  // stimulus builders
  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom));
  endtask

  // header bytes; spoil picks a fixed byte to corrupt, -1 for none
  task automatic push_header(input logic [shd_pkg::TYPE_W-1:0] tc,
                             input logic [shd_pkg::LEN_W-1:0] len, input int spoil);
    logic [7:0] hdr [16];
    hdr[0] = shd_pkg::MARK_A; hdr[1] = shd_pkg::MARK_B;
    hdr[2] = shd_pkg::MARK_A; hdr[3] = shd_pkg::MARK_B;
    hdr[4] = shd_pkg::TAG_T;
    for (int i = 0; i < 7; i++) hdr[5 + i] = tc[shd_pkg::TYPE_W - 1 - 8 * i -: 8];
    hdr[12] = shd_pkg::TAG_LEN;
    hdr[13] = len[23:16]; hdr[14] = len[15:8]; hdr[15] = len[7:0];
    if (spoil >= 0) hdr[spoil] = hdr[spoil] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 16; i++) queue_byte(hdr[i]);
  endtask

  // payload leans toward header-like bytes now and then
  task automatic push_payload(input int n);
    logic [7:0] pick [4];
    pick[0] = shd_pkg::MARK_A; pick[1] = shd_pkg::MARK_B;
    pick[2] = shd_pkg::TAG_T; pick[3] = shd_pkg::TAG_LEN;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) queue_byte(pick[$urandom_range(0, 3)]);
      else queue_byte(8'($urandom));
    end
  endtask

  task automatic push_packet(input logic [shd_pkg::TYPE_W-1:0] tc,
                             input logic [shd_pkg::LEN_W-1:0] len);
    push_header(tc, len, -1);
    push_payload(int'(len));
  endtask

  // input driver
  int gap_left = 0;
  int in_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stream_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data_byte <= stream_q.pop_front();
        gap_left <= (in_calm > 0) ? 0 : pick_gap();
        in_calm <= next_calm(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall driver
  int stall_left = 0;
  int out_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= (out_calm > 0) ? 0 : pick_gap();
      out_calm <= next_calm(out_calm);
    end
  end

  // monitor: predict from accepted bytes, then check accepted results
  always @(posedge clk) begin
    shd_pkg::shd_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: kind %0d type %h len %h byte %h last %0d drop %0d",
                     out_kind, out_type_code, out_payload_length, out_payload_byte,
                     out_last_of_packet, out_dropped_count);
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind || out_type_code !== want.type_code ||
              out_payload_length !== want.payload_length ||
              out_payload_byte !== want.payload_byte ||
              out_last_of_packet !== want.last_of_packet ||
              out_dropped_count !== want.dropped_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: kind %0d type %h len %h byte %h last %0d drop %0d",
                       want.kind, want.type_code, want.payload_length, want.payload_byte,
                       want.last_of_packet, want.dropped_count);
              $display("         got: kind %0d type %h len %h byte %h last %0d drop %0d",
                       out_kind, out_type_code, out_payload_length, out_payload_byte,
                       out_last_of_packet, out_dropped_count);
            end
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sel;
    int len;
    int spots [6];
    spots[0] = 0; spots[1] = 1; spots[2] = 2; spots[3] = 3; spots[4] = 4; spots[5] = 12;
    for (int i = 0; i < shd_pkg::WIN_DEPTH; i++) win[i] = 8'h00;

    // filling window, then drops of extreme bytes
    for (int i = 0; i < 8; i++) queue_byte(8'h00);
    for (int i = 0; i < 8; i++) queue_byte(8'hFF);
    // zero length header with all-ones type, found in a full window
    push_packet({shd_pkg::TYPE_W{1'b1}}, 24'd0);
    // back to back: one byte of all ones, then header-like payload bytes
    push_packet('0, 24'd1);
    stream_q[stream_q.size() - 1] = 8'hFF;
    push_header(56'h01_02_03_04_05_06_07, 24'd2, -1);
    queue_byte(shd_pkg::MARK_A);
    queue_byte(shd_pkg::MARK_B);
    // broken header then a good one
    push_header(56'h0, 24'd3, 4);
    push_packet(56'h80_00_00_00_00_00_01, 24'd3);

    // random sequences, mostly well-formed packets
    while (stream_q.size() < 760) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        push_noise($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 10) len = 0;
        else if (sel < 92) len = $urandom_range(1, 24);
        else len = $urandom_range(25, 300);
        push_packet(shd_pkg::TYPE_W'({$urandom, $urandom}), 24'(len));
      end else if (sel < 80) begin
        push_noise($urandom_range(1, 20));
      end else begin
        push_header(shd_pkg::TYPE_W'({$urandom, $urandom}), 24'($urandom_range(0, 20)),
                    spots[$urandom_range(0, 5)]);
      end
    end

    // all-ones length as the last packet, left open
    push_header(shd_pkg::TYPE_W'({$urandom, $urandom}), {shd_pkg::LEN_W{1'b1}}, -1);
    push_payload(20);

    total_bytes = stream_q.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
